// File: rtl/gfge_pkg.sv
`default_nettype none

package gfge_pkg;

  // Field and register widths
  localparam int PixelW       = 8;
  localparam int GraySumW     = 10;
  localparam int ImageWidthW  = 11;
  localparam int ImageHeightW = 13;
  localparam int RowW         = 12;
  localparam int CfgIndexW    = 1;
  localparam int CfgDataW     = 13;

  // Register reset values and bounds
  localparam logic [ImageWidthW-1:0]  WidthReset  = 11'd640;
  localparam logic [ImageHeightW-1:0] HeightReset = 13'd480;
  localparam logic [ImageHeightW-1:0] HeightMin   = 13'd2;
  localparam logic [ImageHeightW-1:0] HeightLimit = 13'd4096;

  // Register indexes on the configuration port
  localparam logic [CfgIndexW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIndexW-1:0] RegImageHeight = 1'b1;

  // Divide by three as multiply by 683 / 2048; exact for sums below 2048
  localparam int                  GrayProdW  = 19;
  localparam int                  GrayShift  = 11;
  localparam logic [GrayProdW-1:0] GrayRecip = 19'd683;

  function automatic logic [PixelW-1:0] gray_of(input logic [GraySumW-1:0] sum);
    logic [GrayProdW-1:0] prod;
    prod = GrayProdW'(sum) * GrayRecip;
    return prod[GrayShift +: PixelW];
  endfunction

  // Absolute difference of two gray values
  function automatic logic [PixelW-1:0] abs_diff(input logic [PixelW-1:0] a,
                                                 input logic [PixelW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// File: rtl/gfge_ram.sv
`default_nettype none

module gfge_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gray_forward_gradient_edge.sv
// Streaming L1 forward-gradient edge detector. RGB pixels enter in raster order
// on the slave stream; each becomes gray = (r+g+b)/3. From the second row on,
// every input pixel at (i,j) yields the edge value of (i-1,j): |g(i-1,j)-g(i,j)|
// + |g(i-1,j)-g(i-1,j+1)| saturated at 255, with 0 in the last column; the first
// row yields nothing, so each frame gives (height-1)*width results and tlast
// marks the final one. Sustained rate is one pixel per clock unless the output
// stalls, set by the single-port-per-direction line buffer (one read and one
// write per pixel); a result passes the stage-1 and output registers. Width and
// height are clamped to 2..MAX_WIDTH and 2..4096; write them only while idle.
// The line buffer needs no clearing after reset.
`default_nettype none

module gray_forward_gradient_edge
  import gfge_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // slave stream: tdata = {blue, green, red}, red in [7:0]
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [3*PixelW-1:0]   s_axis_tdata_i,
  // master stream: tdata = edge_value; tlast = last_of_frame
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic      [PixelW-1:0]     m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CmpW = (ImageWidthW > WW) ? ImageWidthW : WW;
  localparam logic [CmpW-1:0] WidthMax = CmpW'(MAX_WIDTH);
  localparam logic [CmpW-1:0] WidthMin = CmpW'(2);

  typedef struct packed {
    logic [PixelW-1:0] gray;
    logic [PixelW-1:0] up0;
    logic              first_col;
    logic              last_col;
    logic              emit;
    logic              last_frame;
  } s1_t;

  logic [ImageWidthW-1:0]  image_width_q;
  logic [ImageHeightW-1:0] image_height_q;
  logic [ColW-1:0]         col_q, col_d;
  logic [RowW-1:0]         row_q, row_d;
  logic [PixelW-1:0]       line0_q;
  logic [PixelW-1:0]       above_q;
  logic                    s1_valid_q;
  s1_t                     s1_q, s1_d;
  logic                    out_valid_q;
  logic [PixelW-1:0]       out_edge_q;
  logic                    out_last_q;

  logic [CmpW-1:0]         cfg_w, width_use, col_cmp, col_next;
  logic [ImageHeightW-1:0] height_use, row_cmp, row_next;
  logic [ColW-1:0]         col_eff, rd_addr;
  logic                    last_col, last_row;
  logic [GraySumW-1:0]     pix_sum;
  logic [PixelW-1:0]       pix_gray;
  logic                    in_accept, s1_adv;
  logic [PixelW-1:0]       rd_data, up, edge_val;
  logic [PixelW:0]         edge_sum;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WidthReset;
      image_height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageWidth:  image_width_q  <= cfg_data_i[ImageWidthW-1:0];
        RegImageHeight: image_height_q <= cfg_data_i[ImageHeightW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    cfg_w = CmpW'(image_width_q);
    if (cfg_w < WidthMin) begin
      width_use = WidthMin;
    end else if (cfg_w > WidthMax) begin
      width_use = WidthMax;
    end else begin
      width_use = cfg_w;
    end
    if (image_height_q < HeightMin) begin
      height_use = HeightMin;
    end else if (image_height_q > HeightLimit) begin
      height_use = HeightLimit;
    end else begin
      height_use = image_height_q;
    end
  end

  // Position of the incoming pixel, pulled inside a shrunk frame
  always_comb begin
    col_cmp  = (CmpW'(col_q) >= width_use) ? CmpW'(width_use - CmpW'(1)) : CmpW'(col_q);
    row_cmp  = (ImageHeightW'(row_q) >= height_use) ?
               ImageHeightW'(height_use - ImageHeightW'(1)) : ImageHeightW'(row_q);
    col_next = CmpW'(col_cmp + CmpW'(1));
    row_next = ImageHeightW'(row_cmp + ImageHeightW'(1));
    last_col = col_next >= width_use;
    last_row = row_next >= height_use;
    col_eff  = col_cmp[ColW-1:0];
    rd_addr  = last_col ? '0 : col_next[ColW-1:0];
  end

  // Gray conversion of the incoming word
  assign pix_sum  = GraySumW'(s_axis_tdata_i[0 +: PixelW])
                  + GraySumW'(s_axis_tdata_i[PixelW +: PixelW])
                  + GraySumW'(s_axis_tdata_i[2*PixelW +: PixelW]);
  assign pix_gray = gray_of(pix_sum);

  // Handshake: stage 1 moves on unless it holds a result and the output is full
  assign s1_adv          = s1_valid_q && (!s1_q.emit || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // Advance the raster counters
  always_comb begin
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_next[RowW-1:0];
    end else begin
      col_d = col_next[ColW-1:0];
      row_d = row_cmp[RowW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line buffer: write this pixel's gray, read the next column of the row above
  gfge_ram #(
    .Width (PixelW),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (col_eff),
    .wdata_i (pix_gray),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Hold column 0 of the row above, which the RAM read does not cover
  always_ff @(posedge clk_i) begin
    if (in_accept && (col_eff == '0)) begin
      line0_q <= pix_gray;
    end
  end

  // Stage 1 word
  always_comb begin
    s1_d.gray       = pix_gray;
    s1_d.up0        = line0_q;
    s1_d.first_col  = (col_eff == '0);
    s1_d.last_col   = last_col;
    s1_d.emit       = (row_cmp != '0);
    s1_d.last_frame = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  // Gradient of the pixel above
  always_comb begin
    up       = s1_q.first_col ? s1_q.up0 : above_q;
    edge_sum = (PixelW + 1)'(abs_diff(up, s1_q.gray)) + (PixelW + 1)'(abs_diff(up, rd_data));
    if (s1_q.last_col) begin
      edge_val = '0;
    end else if (edge_sum[PixelW]) begin
      edge_val = '1;
    end else begin
      edge_val = edge_sum[PixelW-1:0];
    end
  end

  // Keep the up-right value as the next column's up value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= '0;
    end else if (s1_adv && !s1_q.last_col) begin
      above_q <= rd_data;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      out_edge_q <= edge_val;
      out_last_q <= s1_q.last_frame;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_edge_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/gfge_checker.sv
`default_nettype none

module gfge_checker
  import gfge_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid_i,
  input wire logic                 s_axis_tready_o,
  input wire logic                 m_axis_tvalid_o,
  input wire logic                 m_axis_tready_i,
  input wire logic [PixelW-1:0]    m_axis_tdata_o,
  input wire logic                 m_axis_tlast_o,
  input wire logic                 cfg_ready_o
);

  // Configuration writes are never stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("cfg_ready_o dropped");

  // An empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // A fresh result follows an accepted input word that passed the stage-1 register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a preceding input word");

  // The frame's final result lies in the last column and is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o == '0))
    else $error("last result of frame is not zero");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind gray_forward_gradient_edge gfge_checker u_gfge_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .cfg_ready_o     (cfg_ready_o)
);

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top
  import gfge_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 10;
  localparam int MaxW        = 1024;
  localparam int RandPixels  = 900;
  localparam int SettleTicks = 6;
  localparam int QuietLimit  = 2000;
  localparam int MaxWait     = 16;

  // One result word: edge value plus end-of-frame mark
  typedef struct packed {
    logic [PixelW-1:0] value;
    logic              last;
  } grad_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [3*PixelW-1:0]  s_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [PixelW-1:0]    m_tdata;        // edge_value [7:0]
  logic                 m_tlast;        // last_of_frame
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = RegImageWidth;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // Pending pixels, expected edge words, bookkeeping
  logic [3*PixelW-1:0] pix_q[$];
  grad_word_t          grad_q[$];
  int  pix_pushed = 0;
  int  pix_taken = 0;
  int  res_seen = 0;
  int  err_cnt = 0;
  int  pix_gap = 0;
  int  rdy_gap = 0;
  logic pix_acc = 1'b0;
  logic res_acc = 1'b0;
  logic burst_mode = 1'b0;

  // Shadow state of the edge pipeline
  logic [ImageWidthW-1:0]  width_reg = WidthReset;
  logic [ImageHeightW-1:0] height_reg = HeightReset;
  logic [PixelW-1:0]       line_buf[MaxW];
  int  above_px = 0;
  int  col_pos = 0;
  int  row_pos = 0;
  int  line_fill = 0;   // columns of the line buffer written so far

  gray_forward_gradient_edge #(.MAX_WIDTH(MaxW)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int abs_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int width_used();
    return clamp_int(int'(width_reg), 2, MaxW);
  endfunction

  function automatic int height_used();
    return clamp_int(int'(height_reg), int'(HeightMin), int'(HeightLimit));
  endfunction

  // Pixels left until the current frame wraps
  function automatic int frame_pixels_left();
    int wu, hu, col, row;
    wu = width_used();
    hu = height_used();
    col = (col_pos >= wu) ? wu - 1 : col_pos;
    row = (row_pos >= hu) ? hu - 1 : row_pos;
    return (hu - 1 - row) * wu + (wu - col);
  endfunction

  // Gray the pixel, emit the gradient of the pixel above, advance position
  task automatic track_pixel(input logic [3*PixelW-1:0] word);
    int wu, hu, col, row, gray, up, up_right, grad;
    logic last_col;
    wu = width_used();
    hu = height_used();
    gray = (int'(word[7:0]) + int'(word[15:8]) + int'(word[23:16])) / 3;
    col = (col_pos >= wu) ? wu - 1 : col_pos;
    row = (row_pos >= hu) ? hu - 1 : row_pos;
    if (row > 0) begin
      up = (col == 0) ? int'(line_buf[0]) : above_px;
      grad = 0;
      last_col = (col + 1 >= wu);
      if (!last_col) begin
        up_right = int'(line_buf[col + 1]);
        grad = abs_gap(up, gray) + abs_gap(up, up_right);
        if (grad > 255) grad = 255;
        above_px = up_right;
      end
      grad_q.push_back('{value: grad[PixelW-1:0], last: last_col && (row + 1 >= hu)});
    end
    line_buf[col] = gray[PixelW-1:0];
    if (col + 1 > line_fill) line_fill = col + 1;
    if (col + 1 >= wu) begin
      col_pos = 0;
      row_pos = (row + 1 >= hu) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: result %0d %s: got %0d, expected %0d", $time, res_seen, what, got,
             want);
    err_cnt++;
  endtask

  // Pixel driver: present the next pending word after a random gap (none in burst mode)
  always @(negedge clk) begin : pixel_driver
    logic nxt_valid;
    nxt_valid = s_tvalid;
    if (rst_n) begin
      if (s_tvalid && pix_acc) begin
        nxt_valid = 1'b0;
        pix_gap = burst_mode ? 0 : $urandom_range(0, MaxWait);
      end
      if (!nxt_valid) begin
        if (pix_gap > 0) begin
          pix_gap--;
        end else if (pix_q.size() > 0) begin
          s_tdata <= pix_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    s_tvalid <= nxt_valid;
  end

  // Result sink: stall for a random gap after each word (none in burst mode)
  always @(negedge clk) begin : result_sink
    logic nxt_ready;
    nxt_ready = 1'b0;
    if (rst_n) begin
      if (res_acc) rdy_gap = burst_mode ? 0 : $urandom_range(0, MaxWait);
      if (rdy_gap > 0) begin
        rdy_gap--;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    m_tready <= nxt_ready;
  end

  // Monitor: check results, predict from accepted pixels, track registers
  always @(posedge clk) begin : monitor
    grad_word_t want;
    pix_acc <= s_tvalid && s_tready;
    res_acc <= m_tvalid && m_tready;
    if (rst_n) begin
      if (m_tvalid && m_tready) begin
        if (grad_q.size() == 0) begin
          report_mismatch("with none expected, value", int'(m_tdata), -1);
        end else begin
          want = grad_q.pop_front();
          if (m_tdata !== want.value) report_mismatch("edge value", int'(m_tdata),
                                                      int'(want.value));
          if (m_tlast !== want.last) report_mismatch("tlast", int'(m_tlast),
                                                     int'(want.last));
        end
        res_seen++;
      end
      if (s_tvalid && s_tready) begin
        track_pixel(s_tdata);
        pix_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegImageWidth) width_reg = cfg_data[ImageWidthW-1:0];
        else height_reg = cfg_data;
      end
    end
  end

  // Watchdog: end the run after a long stretch with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every pixel is taken and every result is in, then let the pipe empty
  task automatic settle();
    while (pix_taken != pix_pushed || grad_q.size() != 0) @(negedge clk);
    repeat (SettleTicks) @(negedge clk);
  endtask

  task automatic push_pixel(input int r, input int g, input int b);
    pix_q.push_back({b[7:0], g[7:0], r[7:0]});
    pix_pushed++;
  endtask

  // Queue n pixels: full random, saturated extremes, or a smooth patch
  task automatic queue_pixels(input int n, input int flavor);
    int base, r, g, b;
    base = $urandom_range(0, 255);
    repeat (n) begin
      case (flavor)
        1: begin
          r = $urandom_range(0, 1) * 255;
          g = $urandom_range(0, 1) * 255;
          b = $urandom_range(0, 1) * 255;
        end
        2: begin
          r = clamp_int(base + int'($urandom_range(0, 8)) - 4, 0, 255);
          g = clamp_int(base + int'($urandom_range(0, 8)) - 4, 0, 255);
          b = clamp_int(base + int'($urandom_range(0, 8)) - 4, 0, 255);
        end
        default: begin
          r = $urandom_range(0, 255);
          g = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
      endcase
      push_pixel(r, g, b);
    end
  endtask

  // New width; never grow past the written part of the line buffer mid-frame
  function automatic logic [CfgDataW-1:0] pick_width();
    int cand;
    case ($urandom_range(0, 9))
      0:       cand = $urandom_range(0, 1);
      1:       cand = $urandom_range(MaxW + 1, 2047);
      2:       cand = MaxW;
      default: cand = $urandom_range(2, 12);
    endcase
    if (row_pos > 0 && clamp_int(cand, 2, MaxW) > line_fill) cand = line_fill;
    return {2'($urandom_range(0, 3)), cand[ImageWidthW-1:0]};
  endfunction

  function automatic logic [CfgDataW-1:0] pick_height();
    int cand;
    case ($urandom_range(0, 9))
      0:       cand = $urandom_range(0, 1);
      1:       cand = $urandom_range(4097, 8191);
      2:       cand = 4096;
      default: cand = $urandom_range(2, 6);
    endcase
    return cand[CfgDataW-1:0];
  endfunction

  initial begin : stimulus
    int sent, n, rem;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 2x2 frames (both registers below range): saturation and frame end
    write_reg(RegImageWidth, 13'd0);
    write_reg(RegImageHeight, 13'd1);
    push_pixel(255, 255, 255);
    push_pixel(0, 0, 0);
    push_pixel(0, 0, 0);
    push_pixel(255, 255, 255);
    push_pixel(255, 255, 254);
    push_pixel(1, 1, 0);
    push_pixel(128, 0, 1);
    push_pixel(0, 255, 0);
    settle();

    // Both registers above range, then shrink width in mid-row
    write_reg(RegImageWidth, 13'h1FFF);
    write_reg(RegImageHeight, 13'h1FFF);
    queue_pixels(4, 0);
    settle();
    write_reg(RegImageWidth, 13'd3);
    queue_pixels(4, 0);
    settle();

    // Shrink height below the current row: that row becomes the last one
    write_reg(RegImageHeight, 13'd2);
    queue_pixels(3, 1);
    settle();

    // Random phases, mostly whole frames, with register changes in between
    sent = 0;
    while (sent < RandPixels) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) write_reg(RegImageWidth, pick_width());
      if ($urandom_range(0, 2) == 0) write_reg(RegImageHeight, pick_height());
      rem = frame_pixels_left();
      if (rem <= 120 && $urandom_range(0, 3) != 0) n = rem;
      else n = $urandom_range(1, 40);
      queue_pixels(n, $urandom_range(0, 4));
      sent += n;
      settle();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
